// ===== src/jsu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescape block
// Result kinds, error codes, decoder modes, the result record and the
// character constants the decoder compares against.
// ----------------------------------------------------------------------------
package jsu_pkg;

   localparam int POSITION_BITS_DEF = 16;
   localparam int REQ_DATA_W        = 8;
   localparam int RSP_DATA_W        = 48;
   localparam int RSP_USER_W        = 2;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_QUOTE      = 3'd1,
      ERR_CONTROL    = 3'd2,
      ERR_ESC_CUT    = 3'd3,
      ERR_UNICODE    = 3'd4,
      ERR_BAD_ESC    = 3'd5,
      ERR_UNTERM     = 3'd6
   } err_type;

   typedef enum logic [2:0] {
      MODE_WAIT = 3'd0,
      MODE_TEXT = 3'd1,
      MODE_ESC  = 3'd2,
      MODE_HEX  = 3'd3,
      MODE_IDLE = 3'd4
   } mode_type;

   typedef struct packed {
      logic [15:0] decoded_length;
      logic [15:0] position;
      err_type     error_code;
      kind_type    kind;
      logic [7:0]  out_byte;
   } rsp_rec_type;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSL    = 8'h5C;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;

   localparam logic [15:0] CP_ONE_MAX = 16'h007F;
   localparam logic [15:0] CP_TWO_MAX = 16'h07FF;

endpackage

`default_nettype wire

// ===== src/json_string_unescape_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_top: streaming unescape of one quoted JSON string
// Checks the opening quote, copies plain bytes, decodes the simple escapes
// and \uXXXX escapes (to 1..3 UTF-8 bytes), and reports completion with the
// decoded length or the first error with its byte offset.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat carries
//  --------+-----+---------------------------------------------------------
//  req_    | in  | one raw byte, or the end-of-input marker on tlast
//  rsp_    | out | one decoded byte, a completion or an error; tlast marks
//          |     | the final beat caused by one request beat
//
//  Each request beat sits in an input register, is decoded there and its
//  0..3 result beats are loaded into a three-entry result buffer.
//  Plain bytes flow at one beat per cycle while rsp_tready is high; a \u
//  escape that expands to two or three bytes holds the input register
//  while the single result port drains the buffer.
//  Reset is synchronous, active high, and returns to waiting for a quote.
//  A stall on rsp_tready holds the buffer; req_tready stays high while the
//  input register is empty, so one beat is taken behind a waiting result.
//
module json_string_unescape_top
   import jsu_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] data_byte
   input  wire logic                  req_tlast,   // end_of_input
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [7:0] out_byte, [10:8] error_code, [26:11] position,
   // [42:27] decoded_length, [47:43] zero
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   output      logic [RSP_USER_W-1:0] rsp_tuser,   // [1:0] kind
   output      logic                  rsp_tlast    // last
);

   localparam int                 PB      = POSITION_BITS;
   localparam logic [PB-1:0]      POS_MAX = {PB{1'b1}};

   // saturating increment of a position counter
   function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
      return (v == POS_MAX) ? POS_MAX : v + 1'b1;
   endfunction

   // saturating add of up to three decoded bytes
   function automatic logic [PB-1:0] sat_add(input logic [PB-1:0] v,
                                             input logic [1:0]    n);
      logic [PB:0] s;
      s = {1'b0, v} + {{(PB-1){1'b0}}, n};
      return s[PB] ? POS_MAX : s[PB-1:0];
   endfunction

   // position or count as seen on the 16-bit result fields
   function automatic logic [15:0] to16(input logic [PB-1:0] v);
      logic [PB+15:0] w;
      w = {16'b0, v};
      return w[15:0];
   endfunction

   function automatic rsp_rec_type byte_rec(input logic [7:0] b);
      rsp_rec_type r;
      r = '0;
      r.kind     = KIND_BYTE;
      r.out_byte = b;
      return r;
   endfunction

   function automatic rsp_rec_type err_rec(input err_type e, input logic [15:0] p);
      rsp_rec_type r;
      r = '0;
      r.kind       = KIND_ERROR;
      r.error_code = e;
      r.position   = p;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Input register
   // ------------------------------------------------------------------------
   logic            in_vld_ff;
   logic [7:0]      in_byte_ff;
   logic            in_eoi_ff;

   // decoder state
   mode_type        mode_ff, mode_in;
   logic [1:0]      hex_cnt_ff, hex_cnt_in;
   logic [15:0]     cp_ff, cp_in;
   logic [PB-1:0]   pos_ff, pos_in;
   logic [PB-1:0]   hex_pos_ff, hex_pos_in;
   logic [PB-1:0]   ocnt_ff, ocnt_in;

   // result buffer, entry 0 is on the port
   rsp_rec_type     grp_ff [3];
   logic [1:0]      grp_cnt_ff;

   rsp_rec_type     res [3];
   logic [1:0]      res_n;
   logic [1:0]      nbytes;

   logic            advance;
   logic            rsp_fire;
   logic            req_fire;
   logic            hex_ok;
   logic [3:0]      hex_val;
   logic [15:0]     cp_new;
   logic [PB-1:0]   pos_inc;
   logic [7:0]      c;

   assign c        = in_byte_ff;
   assign pos_inc  = sat_inc(pos_ff);
   assign cp_new   = {cp_ff[11:0], hex_val};

   // take the decoded item once the buffer is empty or gives up its last beat
   assign advance  = in_vld_ff &&
                     ((grp_cnt_ff == 2'd0) || ((grp_cnt_ff == 2'd1) && rsp_tready));
   assign req_tready = !in_vld_ff || advance;
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // hex digit, either case
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         hex_val = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         hex_val = c[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Next mode
   // ------------------------------------------------------------------------
   always_comb begin
      mode_in = mode_ff;
      if (in_eoi_ff) begin
         mode_in = MODE_WAIT;
      end else begin
         unique case (mode_ff)
            MODE_WAIT: begin
               mode_in = (c == CHAR_QUOTE) ? MODE_TEXT : MODE_IDLE;
            end
            MODE_TEXT: begin
               if (c == CHAR_QUOTE || c < CHAR_SPACE) begin
                  mode_in = MODE_IDLE;
               end else if (c == CHAR_BSL) begin
                  mode_in = MODE_ESC;
               end
            end
            MODE_ESC: begin
               unique case (c) inside
                  CHAR_QUOTE, CHAR_BSL, CHAR_SLASH, CHAR_B,
                  CHAR_F, CHAR_N, CHAR_R, CHAR_T: mode_in = MODE_TEXT;
                  CHAR_U:                         mode_in = MODE_HEX;
                  default:                        mode_in = MODE_IDLE;
               endcase
            end
            MODE_HEX: begin
               if (!hex_ok) begin
                  mode_in = MODE_IDLE;
               end else if (hex_cnt_ff == 2'd3) begin
                  mode_in = MODE_TEXT;
               end
            end
            MODE_IDLE: begin
               mode_in = MODE_IDLE;
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Results and counters for the item in the input register
   // ------------------------------------------------------------------------
   always_comb begin
      res[0]     = '0;
      res[1]     = '0;
      res[2]     = '0;
      res_n      = 2'd0;
      nbytes     = 2'd0;
      hex_cnt_in = hex_cnt_ff;
      cp_in      = cp_ff;
      pos_in     = pos_inc;
      hex_pos_in = hex_pos_ff;

      if (in_eoi_ff) begin
         // marker: report an open string, then rearm everything
         pos_in     = '0;
         hex_pos_in = '0;
         hex_cnt_in = 2'd0;
         cp_in      = '0;
         res_n      = 2'd1;
         unique case (mode_ff)
            MODE_WAIT: res[0] = err_rec(ERR_QUOTE, to16(pos_ff));
            MODE_TEXT: res[0] = err_rec(ERR_UNTERM, to16(pos_ff));
            MODE_ESC:  res[0] = err_rec(ERR_ESC_CUT, to16(pos_ff));
            MODE_HEX:  res[0] = err_rec(ERR_UNICODE, to16(hex_pos_ff));
            default:   res_n  = 2'd0;
         endcase
      end else begin
         unique case (mode_ff)
            MODE_WAIT: begin
               if (c != CHAR_QUOTE) begin
                  res[0] = err_rec(ERR_QUOTE, to16(pos_ff));
                  res_n  = 2'd1;
               end
            end
            MODE_TEXT: begin
               res_n = 2'd1;
               if (c == CHAR_QUOTE) begin
                  res[0].kind           = KIND_DONE;
                  res[0].decoded_length = to16(ocnt_ff);
               end else if (c < CHAR_SPACE) begin
                  res[0] = err_rec(ERR_CONTROL, to16(pos_inc));
               end else if (c == CHAR_BSL) begin
                  res_n = 2'd0;
               end else begin
                  res[0] = byte_rec(c);
                  nbytes = 2'd1;
               end
            end
            MODE_ESC: begin
               res_n  = 2'd1;
               nbytes = 2'd1;
               unique case (c) inside
                  CHAR_QUOTE, CHAR_BSL, CHAR_SLASH: res[0] = byte_rec(c);
                  CHAR_B: res[0] = byte_rec(8'h08);
                  CHAR_F: res[0] = byte_rec(8'h0C);
                  CHAR_N: res[0] = byte_rec(8'h0A);
                  CHAR_R: res[0] = byte_rec(8'h0D);
                  CHAR_T: res[0] = byte_rec(8'h09);
                  CHAR_U: begin
                     res_n      = 2'd0;
                     nbytes     = 2'd0;
                     hex_cnt_in = 2'd0;
                     cp_in      = '0;
                     hex_pos_in = pos_inc;
                  end
                  default: begin
                     nbytes = 2'd0;
                     res[0] = err_rec(ERR_BAD_ESC, to16(pos_inc));
                  end
               endcase
            end
            MODE_HEX: begin
               if (!hex_ok) begin
                  res[0] = err_rec(ERR_UNICODE, to16(hex_pos_ff));
                  res_n  = 2'd1;
               end else if (hex_cnt_ff != 2'd3) begin
                  cp_in      = cp_new;
                  hex_cnt_in = hex_cnt_ff + 2'd1;
               end else begin
                  // fourth digit: encode the code point as UTF-8
                  cp_in      = '0;
                  hex_cnt_in = 2'd0;
                  if (cp_new <= CP_ONE_MAX) begin
                     res[0] = byte_rec(cp_new[7:0]);
                     res_n  = 2'd1;
                  end else if (cp_new <= CP_TWO_MAX) begin
                     res[0] = byte_rec({3'b110, cp_new[10:6]});
                     res[1] = byte_rec({2'b10, cp_new[5:0]});
                     res_n  = 2'd2;
                  end else begin
                     res[0] = byte_rec({4'b1110, cp_new[15:12]});
                     res[1] = byte_rec({2'b10, cp_new[11:6]});
                     res[2] = byte_rec({2'b10, cp_new[5:0]});
                     res_n  = 2'd3;
                  end
                  nbytes = res_n;
               end
            end
            default: begin
               // after completion or an error: count and drop
            end
         endcase
      end

      ocnt_in = in_eoi_ff ? '0 : sat_add(ocnt_ff, nbytes);
   end

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_fire) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
         in_eoi_ff  <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_WAIT;
         hex_cnt_ff <= 2'd0;
         cp_ff      <= '0;
         pos_ff     <= '0;
         hex_pos_ff <= '0;
         ocnt_ff    <= '0;
      end else if (advance) begin
         mode_ff    <= mode_in;
         hex_cnt_ff <= hex_cnt_in;
         cp_ff      <= cp_in;
         pos_ff     <= pos_in;
         hex_pos_ff <= hex_pos_in;
         ocnt_ff    <= ocnt_in;
      end
   end

   // load a new group, or shift the buffer down one beat per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         grp_cnt_ff <= 2'd0;
      end else if (advance) begin
         grp_cnt_ff <= res_n;
      end else if (rsp_fire) begin
         grp_cnt_ff <= grp_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         grp_ff[0] <= res[0];
         grp_ff[1] <= res[1];
         grp_ff[2] <= res[2];
      end else if (rsp_fire) begin
         grp_ff[0] <= grp_ff[1];
         grp_ff[1] <= grp_ff[2];
      end
   end

   // ------------------------------------------------------------------------
   // Result port
   // ------------------------------------------------------------------------
   assign rsp_tvalid = (grp_cnt_ff != 2'd0);
   assign rsp_tlast  = (grp_cnt_ff == 2'd1);
   assign rsp_tuser  = grp_ff[0].kind;
   assign rsp_tdata  = {5'b0, grp_ff[0].decoded_length, grp_ff[0].position,
                        grp_ff[0].error_code, grp_ff[0].out_byte};

endmodule

`default_nettype wire

// ===== src/jsu_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_checker: port-level checks for the JSON string unescape block
// Watches the result channel for field consistency and stall behavior.
// ----------------------------------------------------------------------------
module jsu_checker
   import jsu_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [RSP_USER_W-1:0] rsp_tuser,
   input wire logic                  rsp_tlast
);

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // a decoded byte carries no code, position or length
   a_byte_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_BYTE |-> rsp_tdata[RSP_DATA_W-1:8] == '0)
      else $error("byte beat with side fields set");

   // completion and error always end the group of one request beat
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_BYTE |->
         rsp_tlast && (rsp_tuser == KIND_DONE || rsp_tuser == KIND_ERROR))
      else $error("completion or error beat not last, or bad kind");

   // an error beat names a real code and no byte
   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ERROR |->
         rsp_tdata[10:8] != ERR_NONE && rsp_tdata[7:0] == 8'd0)
      else $error("error beat without code");

   // reset empties the result buffer
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind json_string_unescape_top jsu_checker u_jsu_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for json_string_unescape_top
// Drives buffers of raw bytes, each closed by an end-of-input beat. A
// scoreboard decodes every accepted request beat on its own and checks each
// result beat against the oldest decoded expectation. The bench covers
// directed corner cases, random well-formed and broken strings, random
// stalls on both sides and a long result hold-off.
// ----------------------------------------------------------------------------
module testbench
   import jsu_pkg::*;
();

   // Control codes that the simple escapes decode to
   localparam logic [7:0] CTRL_BS  = 8'h08;
   localparam logic [7:0] CTRL_TAB = 8'h09;
   localparam logic [7:0] CTRL_LF  = 8'h0A;
   localparam logic [7:0] CTRL_FF  = 8'h0C;
   localparam logic [7:0] CTRL_CR  = 8'h0D;
   // Hex digit bases
   localparam logic [7:0] DIGIT_ZERO   = 8'h30;
   localparam logic [7:0] DIGIT_NINE   = 8'h39;
   localparam logic [7:0] UPPER_A      = 8'h41;
   localparam logic [7:0] UPPER_F      = 8'h46;
   localparam logic [7:0] LOWER_A      = 8'h61;
   localparam logic [7:0] LOWER_F      = 8'h66;

   localparam int ITEM_TARGET   = 160;    // skipped bytes bring it near 170
   localparam int HOLD_AT_BEAT  = 40;     // result beat that starts the hold
   localparam int HOLD_CYCLES   = 80;
   localparam int DRAIN_CYCLES  = 16;
   localparam int IDLE_LIMIT    = 2000;
   localparam int MAX_REPORTS   = 10;

   // One result beat: the tdata fields, the kind from tuser and tlast
   typedef struct packed {
      logic [7:0]  out_byte;
      kind_type    kind;
      err_type     code;
      logic [15:0] position;
      logic [15:0] length;
      logic        last;
   } beat_type;

   // -------------------------------------------------------------------------
   // Scoreboard: a private copy of the decoder state, fed with every accepted
   // request beat; the result beats it predicts wait in a FIFO.
   // -------------------------------------------------------------------------
   class unescape_scoreboard;
      beat_type    expected_q[$];
      beat_type    fresh_q[$];
      mode_type    mode;
      logic [1:0]  digit_count;
      logic [15:0] code_point;
      logic [15:0] byte_pos;
      logic [15:0] hex_pos;
      logic [15:0] out_count;
      int          failures;

      function new();
         rearm();
         failures = 0;
      endfunction

      function void rearm();
         mode        = MODE_WAIT;
         digit_count = 2'd0;
         code_point  = 16'd0;
         byte_pos    = 16'd0;
         hex_pos     = 16'd0;
         out_count   = 16'd0;
      endfunction

      // Counters stick at the top instead of wrapping
      function logic [15:0] bump(logic [15:0] v);
         return (v == 16'hFFFF) ? v : v + 16'd1;
      endfunction

      function int hex_nibble(logic [7:0] c);
         if (c >= DIGIT_ZERO && c <= DIGIT_NINE) return int'(c - DIGIT_ZERO);
         if (c >= LOWER_A && c <= LOWER_F) return int'(c - LOWER_A) + 10;
         if (c >= UPPER_A && c <= UPPER_F) return int'(c - UPPER_A) + 10;
         return -1;
      endfunction

      function void add_byte(logic [7:0] b);
         beat_type r;
         r = '0;
         r.out_byte = b;
         r.kind     = KIND_BYTE;
         r.code     = ERR_NONE;
         fresh_q.push_back(r);
         out_count = bump(out_count);
      endfunction

      function void add_error(err_type e, logic [15:0] p);
         beat_type r;
         r = '0;
         r.kind     = KIND_ERROR;
         r.code     = e;
         r.position = p;
         fresh_q.push_back(r);
         mode = MODE_IDLE;
      endfunction

      function void add_utf8(logic [15:0] cp);
         if (cp <= CP_ONE_MAX) begin
            add_byte(cp[7:0]);
         end else if (cp <= CP_TWO_MAX) begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
         end else begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
         end
      endfunction

      // Decode one request beat; returns 0 when the block just skips it
      function bit take_raw_byte(logic [7:0] c, logic eoi);
         beat_type r;
         int       nib;
         bit       acted;
         fresh_q.delete();
         acted = 1'b1;
         r = '0;
         if (eoi) begin
            case (mode)
               MODE_WAIT: add_error(ERR_QUOTE, byte_pos);
               MODE_TEXT: add_error(ERR_UNTERM, byte_pos);
               MODE_ESC:  add_error(ERR_ESC_CUT, byte_pos);
               MODE_HEX:  add_error(ERR_UNICODE, hex_pos);
               default:   ;
            endcase
            rearm();
         end else if (mode == MODE_WAIT) begin
            if (c != CHAR_QUOTE) add_error(ERR_QUOTE, byte_pos);
            else mode = MODE_TEXT;
            byte_pos = bump(byte_pos);
         end else if (mode == MODE_TEXT) begin
            byte_pos = bump(byte_pos);
            if (c == CHAR_QUOTE) begin
               r.kind   = KIND_DONE;
               r.code   = ERR_NONE;
               r.length = out_count;
               fresh_q.push_back(r);
               mode = MODE_IDLE;
            end else if (c < CHAR_SPACE) begin
               add_error(ERR_CONTROL, byte_pos);
            end else if (c == CHAR_BSL) begin
               mode = MODE_ESC;
            end else begin
               add_byte(c);
            end
         end else if (mode == MODE_ESC) begin
            byte_pos = bump(byte_pos);
            mode = MODE_TEXT;
            case (c) inside
               CHAR_QUOTE, CHAR_BSL, CHAR_SLASH: add_byte(c);
               CHAR_B: add_byte(CTRL_BS);
               CHAR_F: add_byte(CTRL_FF);
               CHAR_N: add_byte(CTRL_LF);
               CHAR_R: add_byte(CTRL_CR);
               CHAR_T: add_byte(CTRL_TAB);
               CHAR_U: begin
                  mode        = MODE_HEX;
                  digit_count = 2'd0;
                  code_point  = 16'd0;
                  hex_pos     = byte_pos;
               end
               default: add_error(ERR_BAD_ESC, byte_pos);
            endcase
         end else if (mode == MODE_HEX) begin
            nib = hex_nibble(c);
            byte_pos = bump(byte_pos);
            if (nib < 0) begin
               add_error(ERR_UNICODE, hex_pos);
            end else begin
               code_point = {code_point[11:0], nib[3:0]};
               if (digit_count == 2'd3) begin
                  digit_count = 2'd0;
                  mode = MODE_TEXT;
                  add_utf8(code_point);
                  code_point = 16'd0;
               end else begin
                  digit_count = digit_count + 2'd1;
               end
            end
         end else begin
            // after completion or an error: skip until the marker
            byte_pos = bump(byte_pos);
            acted = 1'b0;
         end
         if (fresh_q.size() > 0) fresh_q[fresh_q.size() - 1].last = 1'b1;
         foreach (fresh_q[i]) expected_q.push_back(fresh_q[i]);
         return acted;
      endfunction

      function void match_result(logic [RSP_DATA_W-1:0] d, logic [RSP_USER_W-1:0] u,
                                 logic l);
         beat_type got;
         beat_type want;
         got.out_byte = d[7:0];
         got.kind     = kind_type'(u);
         got.code     = err_type'(d[10:8]);
         got.position = d[26:11];
         got.length   = d[42:27];
         got.last     = l;
         if (expected_q.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: unexpected result beat kind %0d byte %02h code %0d",
                        $realtime, got.kind, got.out_byte, got.code);
            return;
         end
         want = expected_q.pop_front();
         if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
             got.code !== want.code || got.position !== want.position ||
             got.length !== want.length || got.last !== want.last) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("%0t: result mismatch", $realtime);
               $display("   expected byte %02h kind %0d code %0d pos %0d len %0d last %0d",
                        want.out_byte, want.kind, want.code, want.position, want.length,
                        want.last);
               $display("   actual   byte %02h kind %0d code %0d pos %0d len %0d last %0d",
                        got.out_byte, got.kind, got.code, got.position, got.length,
                        got.last);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void finish_check();
         if (expected_q.size() > 0) begin
            if (failures < MAX_REPORTS)
               $display("%0t: %0d expected result beats never arrived",
                        $realtime, expected_q.size());
            failures += expected_q.size();
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block signals; every input starts at a known value
   // -------------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [7:0] data_byte
   logic                  req_tlast  = 1'b0; // end_of_input
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [7:0] out_byte, [10:8] error_code, [26:11] position,
   // [42:27] decoded_length, [47:43] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;          // [1:0] kind
   logic                  rsp_tlast;          // last

   unescape_scoreboard board = new();

   logic [7:0] raw_q[$];      // bytes of the buffer being built
   int         acted_items  = 0;
   int         results_seen = 0;
   int         idle_cycles  = 0;
   bit         tx_calm      = 1'b0;   // sender skips gaps for this buffer
   bit         rx_calm      = 1'b0;   // receiver skips stalls for a stretch
   bit         hold_done    = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   json_string_unescape_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // -------------------------------------------------------------------------
   // Monitor: sample both channels at the edge. The request side is noted
   // first so a prediction is always in place before its result can show.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            if (board.take_raw_byte(req_tdata, req_tlast)) acted_items++;
         end
         if (rsp_tvalid && rsp_tready) begin
            board.match_result(rsp_tdata, rsp_tuser, rsp_tlast);
            results_seen++;
         end
      end
   end

   // Watchdog: end the run if neither side moves a beat for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $realtime, IDLE_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: stall for a random stretch before each result beat, with
   // calm stretches, and once hold off long enough that the result buffer and
   // the input register fill and req_tready drops.
   // -------------------------------------------------------------------------
   initial begin : drain_results
      int hold;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
         if (!hold_done && results_seen >= HOLD_AT_BEAT) begin
            hold = HOLD_CYCLES;
            hold_done = 1'b1;
         end else begin
            hold = rx_calm ? 0 : $urandom_range(0, 12);
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks
   // -------------------------------------------------------------------------
   task automatic send_beat(input logic [7:0] d, input logic l);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Send the built buffer and close it with the marker beat; the marker's
   // data byte is don't-care, so randomize it to toggle those bits too
   task automatic send_buffer();
      tx_calm = ($urandom_range(0, 3) == 0);
      foreach (raw_q[i]) send_beat(raw_q[i], 1'b0);
      send_beat(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // -------------------------------------------------------------------------
   // Buffer builders
   // -------------------------------------------------------------------------
   function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
      if (nib < 4'd10) return DIGIT_ZERO + {4'd0, nib};
      return (upper ? UPPER_A : LOWER_A) + {4'd0, nib} - 8'd10;
   endfunction

   function automatic logic [7:0] escape_letter(int idx);
      case (idx)
         0: return CHAR_QUOTE;
         1: return CHAR_BSL;
         2: return CHAR_SLASH;
         3: return CHAR_B;
         4: return CHAR_F;
         5: return CHAR_N;
         6: return CHAR_R;
         default: return CHAR_T;
      endcase
   endfunction

   // Printable or high byte that passes through unchanged
   function automatic void add_plain();
      logic [7:0] c;
      do c = 8'($urandom_range(32, 255));
      while (c == CHAR_QUOTE || c == CHAR_BSL);
      raw_q.push_back(c);
   endfunction

   function automatic void add_unicode();
      logic [15:0] cp;
      case ($urandom_range(0, 3))
         0: cp = 16'($urandom_range(0, 16'h007F));
         1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
         2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
         default: begin
            // code-point boundaries, a lone surrogate among them
            case ($urandom_range(0, 6))
               0: cp = 16'h0000;
               1: cp = 16'h007F;
               2: cp = 16'h0080;
               3: cp = 16'h07FF;
               4: cp = 16'h0800;
               5: cp = 16'hD800;
               default: cp = 16'hFFFF;
            endcase
         end
      endcase
      raw_q.push_back(CHAR_BSL);
      raw_q.push_back(CHAR_U);
      for (int i = 3; i >= 0; i--)
         raw_q.push_back(hex_char(cp[i*4 +: 4], $urandom_range(0, 1) == 1));
   endfunction

   // Mostly well-formed strings with random content; the rest are cut short,
   // carry a stray byte or control character, or are plain noise
   function automatic void build_random_buffer();
      int shape;
      int cut;
      raw_q.delete();
      shape = $urandom_range(0, 99);
      if (shape < 6) begin
         repeat ($urandom_range(1, 6)) raw_q.push_back(8'($urandom_range(0, 255)));
         return;
      end
      raw_q.push_back(CHAR_QUOTE);
      repeat ($urandom_range(0, 6)) begin
         case ($urandom_range(0, 5))
            0, 1, 2: add_plain();
            3, 4: begin
               raw_q.push_back(CHAR_BSL);
               raw_q.push_back(escape_letter($urandom_range(0, 7)));
            end
            default: add_unicode();
         endcase
      end
      raw_q.push_back(CHAR_QUOTE);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 2)) raw_q.push_back(8'($urandom_range(0, 255)));
      if (shape >= 72) begin
         cut = $urandom_range(0, raw_q.size() - 1);
         case ($urandom_range(0, 2))
            0: while (raw_q.size() > cut) void'(raw_q.pop_back());
            1: raw_q[cut] = 8'($urandom_range(0, 255));
            default: raw_q[cut] = 8'($urandom_range(0, 31));
         endcase
      end
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // marker on an empty buffer: quote expected at offset zero
      raw_q = {};
      send_buffer();
      // extreme bytes where a quote belongs; the second one is skipped
      raw_q = '{8'hFF, 8'h00};
      send_buffer();
      // control character inside the string
      raw_q = '{CHAR_QUOTE, 8'h1F};
      send_buffer();
      // top code point in mixed case, then a byte past the closing quote
      raw_q = '{CHAR_QUOTE, CHAR_BSL, CHAR_U, "F", "f", "F", "f", CHAR_QUOTE, "z"};
      send_buffer();
      // unknown escape letter
      raw_q = '{CHAR_QUOTE, CHAR_BSL, "x"};
      send_buffer();
      // top two-byte code point with a decoded byte ahead of it
      raw_q = '{CHAR_QUOTE, 8'h7F, CHAR_BSL, CHAR_U, "0", "7", "F", "F"};
      send_buffer();

      while (acted_items < ITEM_TARGET) begin
         build_random_buffer();
         send_buffer();
      end
      req_tvalid <= 1'b0;

      while (board.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      board.finish_check();
      if (board.failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/jsu_pkg.sv
src/json_string_unescape_top.sv
src/jsu_checker.sv
tb/sv/testbench.sv
